// File: rtl/core/ines_chk_pkg.sv
// shared constants, status codes and the byte-wide crc-32 step for the image checker
// no dependencies
`timescale 1ns / 1ps

package ines_chk_pkg;

  localparam int HEADER_BYTES       = 16;
  localparam int PRG_BANK_BYTES_DEF = 16384;
  localparam int CHR_BANK_BYTES_DEF = 8192;

  localparam int COUNT_W = 23;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [7:0] MAGIC_0 = 8'h4E;
  localparam logic [7:0] MAGIC_1 = 8'h45;
  localparam logic [7:0] MAGIC_2 = 8'h53;
  localparam logic [7:0] MAGIC_3 = 8'h1A;

  localparam logic [COUNT_W-1:0] IDX_PRG    = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] IDX_CHR    = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] IDX_MIRROR = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] MAGIC_LEN  = COUNT_W'(4);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_SIZE  = 2'd2,
    ST_NO_PRG    = 2'd3
  } status_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = MAGIC_0;
      2'd1:    m = MAGIC_1;
      2'd2:    m = MAGIC_2;
      default: m = MAGIC_3;
    endcase
    return m;
  endfunction

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/ines_image_checker.sv
// ines image checker top level: header capture, length count, crc-32 of first program bank
// depends on ines_chk_pkg
// latency: the result appears in the cycle after the last byte's transfer
// throughput: one byte per cycle; in_tready drops only while a result waits on out_tready
// the whole per-byte update is one pass through the byte-wide crc step and the size compare
// reset: synchronous active-low rst_n clears the checker state and the result valid; the result data is not reset
// after each result the per-image state (count, crc, header fields) returns to its reset values for the next image
`timescale 1ns / 1ps

module ines_image_checker #(
  parameter int PRG_BANK_BYTES = ines_chk_pkg::PRG_BANK_BYTES_DEF,
  parameter int CHR_BANK_BYTES = ines_chk_pkg::CHR_BANK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rom_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [1:0] status, [9:2] prg_count, [17:10] chr_count,
                                  // [18] vertical_mirror, [50:19] prg_crc, [55:51] zero
);

  localparam int CW = ines_chk_pkg::COUNT_W;
  localparam longint EXP_MAX = longint'(PRG_BANK_BYTES) * 255 + longint'(CHR_BANK_BYTES) * 255
                               + ines_chk_pkg::HEADER_BYTES;
  localparam int EXP_W = $clog2(EXP_MAX + 1);
  localparam int CMP_W = (EXP_W > CW) ? EXP_W : CW;
  localparam logic [CMP_W-1:0] PRG_K = CMP_W'(PRG_BANK_BYTES);
  localparam logic [CMP_W-1:0] CHR_K = CMP_W'(CHR_BANK_BYTES);
  localparam logic [CMP_W-1:0] HDR_K = CMP_W'(ines_chk_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] CRC_BEGIN = CW'(ines_chk_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] CRC_END   = CW'(ines_chk_pkg::HEADER_BYTES + PRG_BANK_BYTES);

  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic          magic_ok_r, magic_ok_nxt;
  logic [7:0]    prg_r, prg_nxt;
  logic [7:0]    chr_r, chr_nxt;
  logic          mirror_r, mirror_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [55:0]   out_data_r, out_data_nxt;

  logic          in_xfer;
  logic [CW-1:0] cnt_upd;
  logic [31:0]   crc_upd;
  logic          magic_upd;
  logic [7:0]    prg_upd, chr_upd;
  logic          mirror_upd;
  logic [CMP_W-1:0] expected;
  ines_chk_pkg::status_t status;
  logic [31:0]   crc_out;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // per-byte header capture, crc and count
  always_comb begin
    magic_upd  = magic_ok_r;
    prg_upd    = prg_r;
    chr_upd    = chr_r;
    mirror_upd = mirror_r;
    if (count_r < ines_chk_pkg::MAGIC_LEN) begin
      if (in_tdata != ines_chk_pkg::magic_byte(count_r[1:0])) begin
        magic_upd = 1'b0;
      end
    end else if (count_r == ines_chk_pkg::IDX_PRG) begin
      prg_upd = in_tdata;
    end else if (count_r == ines_chk_pkg::IDX_CHR) begin
      chr_upd = in_tdata;
    end else if (count_r == ines_chk_pkg::IDX_MIRROR) begin
      mirror_upd = in_tdata[0];
    end
    if (count_r >= CRC_BEGIN && count_r < CRC_END) begin
      crc_upd = ines_chk_pkg::crc_byte(crc_r, in_tdata);
    end else begin
      crc_upd = crc_r;
    end
    cnt_upd = (count_r != ines_chk_pkg::COUNT_MAX) ? count_r + CW'(1) : count_r;
  end

  // end-of-image checks
  always_comb begin
    expected = CMP_W'(prg_upd) * PRG_K + CMP_W'(chr_upd) * CHR_K + HDR_K;
    if (!magic_upd || cnt_upd < ines_chk_pkg::MAGIC_LEN) begin
      status = ines_chk_pkg::ST_BAD_MAGIC;
    end else if (CMP_W'(cnt_upd) != expected) begin
      status = ines_chk_pkg::ST_BAD_SIZE;
    end else if (prg_upd == 8'd0) begin
      status = ines_chk_pkg::ST_NO_PRG;
    end else begin
      status = ines_chk_pkg::ST_OK;
    end
    crc_out = (status == ines_chk_pkg::ST_OK) ? ~crc_upd : 32'd0;
  end

  always_comb begin
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    magic_ok_nxt  = magic_ok_r;
    prg_nxt       = prg_r;
    chr_nxt       = chr_r;
    mirror_nxt    = mirror_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (in_xfer) begin
      if (in_tlast) begin
        count_nxt     = '0;
        crc_nxt       = ines_chk_pkg::CRC_INIT;
        magic_ok_nxt  = 1'b1;
        prg_nxt       = 8'd0;
        chr_nxt       = 8'd0;
        mirror_nxt    = 1'b0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = {5'd0, crc_out, mirror_upd, chr_upd, prg_upd, status};
      end else begin
        count_nxt    = cnt_upd;
        crc_nxt      = crc_upd;
        magic_ok_nxt = magic_upd;
        prg_nxt      = prg_upd;
        chr_nxt      = chr_upd;
        mirror_nxt   = mirror_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= ines_chk_pkg::CRC_INIT;
      magic_ok_r  <= 1'b1;
      prg_r       <= 8'd0;
      chr_r       <= 8'd0;
      mirror_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      magic_ok_r  <= magic_ok_nxt;
      prg_r       <= prg_nxt;
      chr_r       <= chr_nxt;
      mirror_r    <= mirror_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // last byte transfer always yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> out_valid_r)
    else $error("result missing after last byte");

  // state returns to reset after a result
  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> (count_r == '0 && crc_r == ines_chk_pkg::CRC_INIT && magic_ok_r))
    else $error("state not cleared after last byte");

  // a non-last byte never invents a result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tlast && !out_valid_r) |=> !out_valid_r)
    else $error("result without last byte");

  // length advances or saturates on a non-last byte
  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tlast) |=> (count_r != '0))
    else $error("byte count did not advance");

endmodule
